// ----- hdl/dctcpwc_pkg.sv -----
// Shared types and constants for the DCTCP window control block.
// Item structs, register indexes, reset values and controller commands.
// No dependencies.
package dctcpwc_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// alpha fraction bits; alpha_frac in out_item_t is FB + 1 bits wide
	localparam int ALPHA_FRAC_BITS = 10;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  segments_acked;
		logic [31:0] rtt_sample;
		logic        ecn_echo;
		logic [2:0]  event_code;
		logic [2:0]  new_state;
	} in_item_t;

	typedef struct packed {
		logic [31:0] window_bytes;
		logic [31:0] threshold_bytes;
		logic [2:0]  conn_phase;
		logic [10:0] alpha_frac;
		logic [31:0] rtt_now;
		logic [31:0] rto_now;
	} out_item_t;

	localparam logic [1:0] OP_ACK   = 2'd0;
	localparam logic [1:0] OP_EVENT = 2'd1;
	localparam logic [1:0] OP_STATE = 2'd2;

	localparam logic [2:0] EV_LOSS    = 3'd0;
	localparam logic [2:0] EV_TIMEOUT = 3'd1;
	localparam logic [2:0] EV_ECN     = 3'd2;
	localparam logic [2:0] EV_FAST    = 3'd3;

	localparam logic [2:0] PH_OPEN     = 3'd0;
	localparam logic [2:0] PH_CWR      = 3'd2;
	localparam logic [2:0] PH_RECOVERY = 3'd3;
	localparam logic [2:0] PH_LOSS     = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MSS      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CWND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT     = 2'd3;

	localparam logic [15:0] MSS_RST       = 16'd1460;
	localparam logic [31:0] MAX_CWND_RST  = 32'd65535;
	localparam logic [3:0]  GAIN_RST      = 4'd4;
	localparam logic [31:0] INIT_CWND_RST = 32'd14600;
	localparam logic [31:0] THRESH_RST    = 32'h7fffffff;
	localparam logic [31:0] U32_MAX       = 32'hffffffff;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_ACK_MUL1,
		CMD_ACK_MUL2,
		CMD_DIV_AVOID,
		CMD_ACK_GROW,
		CMD_CLR_CNT,
		CMD_ALPHA_MUL1,
		CMD_ALPHA_MUL2,
		CMD_DIV_ALPHA,
		CMD_ALPHA_FIN,
		CMD_RED_MUL,
		CMD_EVENT_FIN,
		CMD_STATE_FIN,
		CMD_OUT_LOAD
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] code;
		logic [2:0] new_state;
		logic       avoid;
		logic       win_ge_thr;
		logic       win_end;
		logic       total_zero;
		logic       div_done;
	} dp_status_t;

endpackage

// ----- hdl/dctcp_window_control_unit.sv -----
// DCTCP window control, top level: controller plus datapath; one item at a time.
// An ack may run the avoidance division and, at a window end, the alpha division, both
// in the shared divider at one quotient bit per cycle.
// The next item is taken the cycle after its result is registered.
// Reset: state and configuration registers load their defaults at once, no clearing pass.
module dctcp_window_control_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  dctcpwc_pkg::in_item_t              in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output dctcpwc_pkg::out_item_t             out_data,
	input  logic                               cfg_we,
	input  logic [dctcpwc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dctcpwc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dctcpwc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	dctcpwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	dctcpwc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.out_data  (out_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted item did not make the block busy");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.conn_phase <= PH_LOSS)
		else $error("phase out of range");
endmodule

// ----- hdl/dctcpwc_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the datapath for the avoidance and alpha divisions.
module dctcpwc_div #(
	parameter int DW = 59,
	parameter int VW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] div_q;
	logic [VW:0]   shifted;
	logic          ge;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign ge      = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? VW'(shifted - {1'b0, div_q}) : shifted[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ----- hdl/dctcpwc_dp.sv -----
// Datapath: connection state, configuration registers, multiply steps,
// divider and result register. Depends on dctcpwc_pkg and dctcpwc_div.
module dctcpwc_dp (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  dctcpwc_pkg::in_item_t                     in_data,
	input  dctcpwc_pkg::dp_cmd_t                      cmd,
	input  logic                                      cfg_we,
	input  logic [dctcpwc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dctcpwc_pkg::CFG_DATA_W-1:0]        cfg_data,
	output dctcpwc_pkg::dp_status_t                   status,
	output dctcpwc_pkg::out_item_t                    out_data
);
	import dctcpwc_pkg::*;

	localparam int FB = ALPHA_FRAC_BITS;
	localparam int AW = FB + 1;
	localparam int TW = AW + 15;        // (2^g - 1) * alpha
	localparam int DW = FB + 49;        // EWMA numerator width
	localparam int RW = FB + 34;        // window * (2^(FB+1) - alpha)
	localparam logic [AW-1:0] ONE   = AW'(1) << FB;
	localparam logic [FB+1:0] SCALE = (FB + 2)'(1) << (FB + 1);

	// state and configuration
	logic [15:0]   mss_q;
	logic [31:0]   max_cwnd_q;
	logic [3:0]    gain_q;
	logic [31:0]   window_q;
	logic [31:0]   thresh_q;
	logic [2:0]    phase_q;
	logic [AW-1:0] alpha_q;
	logic [31:0]   marked_q;
	logic [31:0]   total_q;
	logic [31:0]   rvar_q;
	logic [31:0]   rtt_q;

	// per-item working registers
	in_item_t      item_q;
	logic [23:0]   add_s1;
	logic [39:0]   prod_s2;
	logic [TW-1:0] t_q;
	logic [DW-1:0] num_q;
	logic [RW-1:0] red_q;
	out_item_t     out_q;

	logic          div_start;
	logic [DW-1:0] div_dvd;
	logic [31:0]   div_dvs;
	logic          div_done;
	logic [DW-1:0] div_quo;

	logic [31:0]   two_mss;
	logic [31:0]   dthr;
	logic [AW-1:0] a_clip;
	logic [FB+1:0] a_diff;
	logic [32:0]   sum_w;
	logic [31:0]   sat_w;
	logic [DW-1:0] inc;
	logic [DW:0]   sum_av;
	logic [31:0]   grown;
	logic [31:0]   new_win;
	logic [33:0]   var_sum;
	logic [32:0]   tot_sum;
	logic [32:0]   mrk_sum;
	logic [31:0]   tot_sat;
	logic [31:0]   mrk_sat;
	logic [34:0]   rto_sum;
	logic [AW-1:0] alpha_new;
	logic [31:0]   half_win;

	assign div_start = (cmd == CMD_DIV_AVOID) || (cmd == CMD_DIV_ALPHA);
	assign div_dvd   = (cmd == CMD_DIV_AVOID) ? DW'(prod_s2) : (num_q >> gain_q);
	assign div_dvs   = (cmd == CMD_DIV_AVOID) ? ((window_q == '0) ? 32'd1 : window_q)
	                                          : total_q;

	dctcpwc_div #(.DW(DW), .VW(32)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		two_mss = {15'd0, mss_q, 1'b0};
		dthr    = red_q[FB+32:FB+1];
		if (dthr < two_mss)
			dthr = two_mss;
		half_win = window_q >> 1;
		if (half_win < two_mss)
			half_win = two_mss;
		a_clip = (alpha_q > ONE) ? ONE : alpha_q;
		a_diff = SCALE - (FB + 2)'(a_clip);

		// window growth
		sum_w  = {1'b0, window_q} + {9'd0, add_s1};
		sat_w  = sum_w[32] ? U32_MAX : sum_w[31:0];
		inc    = (div_quo == '0) ? DW'(1) : div_quo;
		sum_av = (DW + 1)'(window_q) + {1'b0, inc};
		if (phase_q == PH_RECOVERY) begin
			grown = sat_w;
		end else if (window_q < thresh_q) begin
			grown = (sat_w > thresh_q) ? thresh_q : sat_w;
		end else begin
			grown = (sum_av > (DW + 1)'(U32_MAX)) ? U32_MAX : sum_av[31:0];
		end
		if (grown > max_cwnd_q)
			grown = max_cwnd_q;
		new_win = (item_q.segments_acked == '0) ? window_q : grown;

		var_sum = {2'd0, rvar_q} + {1'b0, rvar_q, 1'b0} + {2'd0, item_q.rtt_sample};
		tot_sum = {1'b0, total_q} + {9'd0, add_s1};
		mrk_sum = {1'b0, marked_q} + {9'd0, add_s1};
		tot_sat = tot_sum[32] ? U32_MAX : tot_sum[31:0];
		mrk_sat = mrk_sum[32] ? U32_MAX : mrk_sum[31:0];
		rto_sum = {3'd0, rtt_q} + {1'b0, rvar_q, 2'd0};
		alpha_new = (div_quo > DW'(ONE)) ? ONE : div_quo[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mss_q       <= MSS_RST;
			max_cwnd_q  <= MAX_CWND_RST;
			gain_q      <= GAIN_RST;
			window_q    <= INIT_CWND_RST;
			thresh_q    <= THRESH_RST;
			phase_q     <= PH_OPEN;
			alpha_q     <= ONE;
			marked_q    <= '0;
			total_q     <= '0;
			rvar_q      <= '0;
			rtt_q       <= '0;
		end else begin
			case (cmd)
				CMD_ACK_GROW: begin
					window_q <= new_win;
					rtt_q    <= item_q.rtt_sample;
					rvar_q   <= (rvar_q == '0) ? (item_q.rtt_sample >> 1) : var_sum[33:2];
					total_q  <= tot_sat;
					if (item_q.ecn_echo)
						marked_q <= mrk_sat;
				end
				CMD_CLR_CNT: begin
					marked_q <= '0;
					total_q  <= '0;
				end
				CMD_ALPHA_FIN: begin
					alpha_q  <= alpha_new;
					marked_q <= '0;
					total_q  <= '0;
				end
				CMD_EVENT_FIN: begin
					case (item_q.event_code)
						EV_LOSS: begin
							thresh_q <= dthr;
							window_q <= dthr;
							phase_q  <= PH_RECOVERY;
						end
						EV_TIMEOUT: begin
							thresh_q <= half_win;
							window_q <= {16'd0, mss_q};
							phase_q  <= PH_LOSS;
							alpha_q  <= ONE;
							marked_q <= '0;
							total_q  <= '0;
						end
						EV_ECN: begin
							if (!(window_q < thresh_q)) begin
								thresh_q <= dthr;
								window_q <= dthr;
							end
							phase_q <= PH_CWR;
						end
						EV_FAST: phase_q <= PH_RECOVERY;
						default: ;
					endcase
				end
				CMD_STATE_FIN: begin
					if (item_q.new_state <= PH_LOSS) begin
						phase_q <= item_q.new_state;
						if (item_q.new_state == PH_RECOVERY || item_q.new_state == PH_LOSS)
							thresh_q <= dthr;
					end
				end
				default: ;
			endcase
			// the user must write only while idle; the block itself does not enforce it
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MSS:      mss_q      <= cfg_data[15:0];
					REG_MAX_CWND: max_cwnd_q <= cfg_data;
					REG_GAIN:     gain_q     <= cfg_data[3:0];
					REG_INIT:     window_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD:       item_q  <= in_data;
			CMD_ACK_MUL1:   add_s1  <= 24'({16'd0, item_q.segments_acked} * {8'd0, mss_q});
			CMD_ACK_MUL2:   prod_s2 <= 40'(add_s1) * 40'(mss_q);
			CMD_ALPHA_MUL1: t_q     <= (TW'(alpha_q) << gain_q) - TW'(alpha_q);
			CMD_ALPHA_MUL2: num_q   <= DW'(t_q) * DW'(total_q) + (DW'(marked_q) << FB);
			CMD_RED_MUL:    red_q   <= RW'(window_q) * RW'(a_diff);
			CMD_OUT_LOAD: begin
				out_q.window_bytes    <= window_q;
				out_q.threshold_bytes <= thresh_q;
				out_q.conn_phase      <= phase_q;
				out_q.alpha_frac      <= 11'(alpha_q);
				out_q.rtt_now         <= rtt_q;
				out_q.rto_now         <= (rto_sum > 35'(U32_MAX)) ? U32_MAX : rto_sum[31:0];
			end
			default: ;
		endcase
	end

	assign status.op         = item_q.operation;
	assign status.code       = item_q.event_code;
	assign status.new_state  = item_q.new_state;
	assign status.avoid      = (item_q.segments_acked != '0) && (phase_q != PH_RECOVERY)
	                           && !(window_q < thresh_q);
	assign status.win_ge_thr = !(window_q < thresh_q);
	assign status.win_end    = total_q >= window_q;
	assign status.total_zero = total_q == '0;
	assign status.div_done   = div_done;
	assign out_data          = out_q;
endmodule

// ----- hdl/dctcpwc_ctrl.sv -----
// Controller: sequences the datapath steps for one item at a time and
// owns the channel handshakes. Depends on dctcpwc_pkg.
module dctcpwc_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  logic                    out_stall,
	output dctcpwc_pkg::dp_cmd_t    cmd,
	input  dctcpwc_pkg::dp_status_t status
);
	import dctcpwc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISPATCH, ST_MUL1, ST_MUL2, ST_DIVS, ST_DIVW, ST_GROW,
		ST_WEND, ST_CLR, ST_AM1, ST_AM2, ST_ADIVS, ST_ADIVW, ST_AFIN,
		ST_RMUL, ST_EFIN, ST_SFIN, ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		unique case (state_q)
			ST_IDLE:  cmd = in_valid ? CMD_LOAD : CMD_NONE;
			ST_MUL1:  cmd = CMD_ACK_MUL1;
			ST_MUL2:  cmd = CMD_ACK_MUL2;
			ST_DIVS:  cmd = CMD_DIV_AVOID;
			ST_GROW:  cmd = CMD_ACK_GROW;
			ST_CLR:   cmd = CMD_CLR_CNT;
			ST_AM1:   cmd = CMD_ALPHA_MUL1;
			ST_AM2:   cmd = CMD_ALPHA_MUL2;
			ST_ADIVS: cmd = CMD_DIV_ALPHA;
			ST_AFIN:  cmd = CMD_ALPHA_FIN;
			ST_RMUL:  cmd = CMD_RED_MUL;
			ST_EFIN:  cmd = CMD_EVENT_FIN;
			ST_SFIN:  cmd = CMD_STATE_FIN;
			ST_OUT:   cmd = out_free ? CMD_OUT_LOAD : CMD_NONE;
			default:  cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_DISPATCH;
				ST_DISPATCH: begin
					case (status.op)
						OP_ACK: state_q <= ST_MUL1;
						OP_EVENT: begin
							if (status.code == EV_LOSS || (status.code == EV_ECN && status.win_ge_thr))
								state_q <= ST_RMUL;
							else
								state_q <= ST_EFIN;
						end
						OP_STATE: begin
							if (status.new_state == PH_RECOVERY || status.new_state == PH_LOSS)
								state_q <= ST_RMUL;
							else
								state_q <= ST_SFIN;
						end
						default: state_q <= ST_OUT;
					endcase
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= status.avoid ? ST_DIVS : ST_GROW;
				ST_DIVS: state_q <= ST_DIVW;
				ST_DIVW: if (status.div_done) state_q <= ST_GROW;
				ST_GROW: state_q <= ST_WEND;
				ST_WEND: begin
					if (!status.win_end)
						state_q <= ST_OUT;
					else if (status.total_zero)
						state_q <= ST_CLR;
					else
						state_q <= ST_AM1;
				end
				ST_CLR:   state_q <= ST_OUT;
				ST_AM1:   state_q <= ST_AM2;
				ST_AM2:   state_q <= ST_ADIVS;
				ST_ADIVS: state_q <= ST_ADIVW;
				ST_ADIVW: if (status.div_done) state_q <= ST_AFIN;
				ST_AFIN:  state_q <= ST_OUT;
				ST_RMUL:  state_q <= (status.op == OP_EVENT) ? ST_EFIN : ST_SFIN;
				ST_EFIN:  state_q <= ST_OUT;
				ST_SFIN:  state_q <= ST_OUT;
				ST_OUT:   if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- verif/dctcp_window_control_unit_tb.sv -----
// Testbench for dctcp_window_control_unit: random and directed acks, events and
// state changes under random idling, checked against an in-bench window model.
// Depends on dctcpwc_pkg and the RTL of the block.
`timescale 1ns / 100ps

module dctcp_window_control_unit_tb;
	import dctcpwc_pkg::*;

	class window_scoreboard;
		// configuration copy
		logic [15:0] mss;
		logic [31:0] max_cwnd;
		logic [3:0]  gain_shift;
		logic [31:0] init_cwnd;
		// connection state copy
		logic [31:0] window;
		logic [31:0] threshold;
		logic [2:0]  phase;
		logic [10:0] alpha;
		logic [31:0] marked_bytes;
		logic [31:0] total_bytes;
		logic [31:0] rtt_var;
		logic [31:0] rtt_last;
		out_item_t   expected_q[$];
		int          mismatches;

		function new();
			mss = MSS_RST;
			max_cwnd = MAX_CWND_RST;
			gain_shift = GAIN_RST;
			init_cwnd = INIT_CWND_RST;
			window = INIT_CWND_RST;
			threshold = THRESH_RST;
			phase = PH_OPEN;
			alpha = 11'd1024;
			marked_bytes = 0;
			total_bytes = 0;
			rtt_var = 0;
			rtt_last = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
			case (idx)
				REG_MSS: mss = v[15:0];
				REG_MAX_CWND: max_cwnd = v;
				REG_GAIN: gain_shift = v[3:0];
				REG_INIT: begin
					init_cwnd = v;
					window = v;
				end
			endcase
		endfunction

		function logic [31:0] sat(logic [63:0] v);
			return (v > 64'hffffffff) ? U32_MAX : v[31:0];
		endfunction

		function logic [31:0] reduced_window();
			logic [63:0] t;
			logic [31:0] two_mss;
			t = ({32'd0, window} * (64'd2048 - {53'd0, alpha})) >> 11;
			two_mss = {15'd0, mss, 1'b0};
			return (t[31:0] > two_mss) ? t[31:0] : two_mss;
		endfunction

		function void grow(logic [7:0] segs);
			logic [63:0] add, inc;
			logic [31:0] w;
			if (segs == 0) return;
			add = segs * mss;
			if (phase == PH_RECOVERY) begin
				w = sat(window + add);
			end else if (window < threshold) begin
				w = sat(window + add);
				if (w > threshold) w = threshold;
			end else begin
				inc = (add * mss) / ((window != 0) ? {32'd0, window} : 64'd1);
				if (inc == 0) inc = 1;
				w = sat(window + inc);
			end
			window = (w < max_cwnd) ? w : max_cwnd;
		endfunction

		function void update_alpha();
			logic [127:0] g, num, den, a;
			if (total_bytes == 0) return;
			g = 128'd1 << gain_shift;
			num = (g - 1) * alpha * total_bytes + ({96'd0, marked_bytes} << 10);
			den = g * total_bytes;
			a = num / den;
			alpha = (a > 1024) ? 11'd1024 : a[10:0];
		endfunction

		function void note_input(in_item_t it);
			logic [31:0] acked, half, two_mss;
			out_item_t r;
			two_mss = {15'd0, mss, 1'b0};
			case (it.operation)
				OP_ACK: begin
					acked = it.segments_acked * mss;
					grow(it.segments_acked);
					rtt_last = it.rtt_sample;
					if (rtt_var == 0) rtt_var = it.rtt_sample >> 1;
					else rtt_var = 32'((64'd3 * rtt_var + it.rtt_sample) >> 2);
					total_bytes = sat(total_bytes + acked);
					if (it.ecn_echo) marked_bytes = sat(marked_bytes + acked);
					if (total_bytes >= window) begin
						update_alpha();
						marked_bytes = 0;
						total_bytes = 0;
					end
				end
				OP_EVENT: case (it.event_code)
					EV_LOSS: begin
						threshold = reduced_window();
						window = threshold;
						phase = PH_RECOVERY;
					end
					EV_TIMEOUT: begin
						half = window >> 1;
						threshold = (half > two_mss) ? half : two_mss;
						window = {16'd0, mss};
						phase = PH_LOSS;
						alpha = 11'd1024;
						marked_bytes = 0;
						total_bytes = 0;
					end
					EV_ECN: begin
						if (!(window < threshold)) begin
							threshold = reduced_window();
							window = threshold;
						end
						phase = PH_CWR;
					end
					EV_FAST: phase = PH_RECOVERY;
					default: ;
				endcase
				OP_STATE: if (it.new_state <= PH_LOSS) begin
					phase = it.new_state;
					if (phase == PH_RECOVERY || phase == PH_LOSS)
						threshold = reduced_window();
				end
				default: ;
			endcase
			r.window_bytes = window;
			r.threshold_bytes = threshold;
			r.conn_phase = phase;
			r.alpha_frac = alpha;
			r.rtt_now = rtt_last;
			r.rto_now = sat(rtt_last + 64'd4 * rtt_var);
			expected_q.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			bit bad;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			e = expected_q.pop_front();
			bad = (e.window_bytes !== got.window_bytes) ||
				(e.threshold_bytes !== got.threshold_bytes) ||
				(e.conn_phase !== got.conn_phase) || (e.alpha_frac !== got.alpha_frac) ||
				(e.rtt_now !== got.rtt_now) || (e.rto_now !== got.rto_now);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp win %0d thr %0d ph %0d a %0d rtt %0d rto %0d | %s",
						e.window_bytes, e.threshold_bytes, e.conn_phase, e.alpha_frac,
						e.rtt_now, e.rto_now,
						$sformatf("got win %0d thr %0d ph %0d a %0d rtt %0d rto %0d",
							got.window_bytes, got.threshold_bytes, got.conn_phase,
							got.alpha_frac, got.rtt_now, got.rto_now));
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_item_t out_data;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	window_scoreboard sb;
	bit calm = 0;       // no idling on either side
	int hold_off = 0;   // long receiver stall request, in cycles
	int idle_cycles = 0;

	localparam int WATCHDOG = 20000;

	always #4 clk = ~clk;

	dctcp_window_control_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		if (in_valid && !in_stall) sb.note_input(in_data);
		if (out_valid && !out_stall) sb.check_result(out_data);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: random stalls, plus long hold-offs on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_stall <= 1;
				hold_off--;
			end else if (calm) begin
				out_stall <= 0;
			end else begin
				out_stall <= ($urandom_range(99) < 36);
			end
		end
	end

	// valid stays up between items sent back to back
	task automatic send_item(in_item_t it);
		if (!calm) begin
			while ($urandom_range(99) < 36) begin
				in_valid <= 0;
				@(negedge clk);
			end
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	function automatic in_item_t rand_item();
		in_item_t it;
		int r;
		it = '0;
		it.segments_acked = 8'($urandom_range(255));
		it.rtt_sample = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(5000);
		it.ecn_echo = 1'($urandom_range(1));
		it.event_code = ($urandom_range(15) == 0) ? 3'($urandom_range(7))
		                                          : 3'($urandom_range(3));
		it.new_state = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
		                                        : 3'($urandom_range(4));
		r = $urandom_range(99);
		if (r < 65) it.operation = OP_ACK;
		else if (r < 80) it.operation = OP_EVENT;
		else if (r < 95) it.operation = OP_STATE;
		else it.operation = 2'd3;
		// keep segments small most of the time so windows grow gradually
		if ($urandom_range(3) != 0) it.segments_acked = 8'($urandom_range(4));
		return it;
	endfunction

	function automatic in_item_t mk(logic [1:0] op, logic [7:0] segs, logic [31:0] rtt,
			logic ecn, logic [2:0] code, logic [2:0] st);
		in_item_t it;
		it.operation = op;
		it.segments_acked = segs;
		it.rtt_sample = rtt;
		it.ecn_echo = ecn;
		it.event_code = code;
		it.new_state = st;
		return it;
	endfunction

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: every op, extremes, special cases
		calm = 1;
		send_item(mk(OP_ACK, 8'd0, 32'd100, 1'b0, 3'd0, 3'd0));
		send_item(mk(OP_ACK, 8'd255, U32_MAX, 1'b1, 3'd7, 3'd7));
		send_item(mk(OP_ACK, 8'd10, 32'd200, 1'b1, 3'd0, 3'd0));
		send_item(mk(OP_ACK, 8'd40, 32'd0, 1'b0, 3'd0, 3'd0));
		send_item(mk(OP_EVENT, 8'd0, 32'd0, 1'b0, EV_ECN, 3'd0));
		send_item(mk(OP_EVENT, 8'd0, 32'd0, 1'b0, EV_LOSS, 3'd0));
		send_item(mk(OP_ACK, 8'd3, 32'd50, 1'b1, 3'd0, 3'd0));
		send_item(mk(OP_EVENT, 8'd0, 32'd0, 1'b0, EV_FAST, 3'd0));
		send_item(mk(OP_EVENT, 8'd0, 32'd0, 1'b0, 3'd4, 3'd0));
		send_item(mk(OP_EVENT, 8'd0, 32'd0, 1'b0, 3'd7, 3'd0));
		send_item(mk(OP_EVENT, 8'd0, 32'd0, 1'b0, EV_TIMEOUT, 3'd0));
		send_item(mk(OP_STATE, 8'd0, 32'd0, 1'b0, 3'd0, PH_RECOVERY));
		send_item(mk(OP_STATE, 8'd0, 32'd0, 1'b0, 3'd0, PH_LOSS));
		send_item(mk(OP_STATE, 8'd0, 32'd0, 1'b0, 3'd0, 3'd7));
		send_item(mk(OP_STATE, 8'd0, 32'd0, 1'b0, 3'd0, PH_OPEN));
		send_item(mk(2'd3, 8'hff, U32_MAX, 1'b1, 3'd7, 3'd7));
		drain();

		// zero window and one-byte mss after a change to the loss state
		write_reg(REG_INIT, 32'd0);
		write_reg(REG_MSS, 32'd1);
		send_item(mk(OP_STATE, 8'd0, 32'd0, 1'b0, 3'd0, PH_LOSS));
		send_item(mk(OP_ACK, 8'd1, 32'd10, 1'b1, 3'd0, 3'd0));
		send_item(mk(OP_ACK, 8'd1, 32'd10, 1'b0, 3'd0, 3'd0));
		drain();

		// random phases over several register settings
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_MSS, 32'd1460); write_reg(REG_MAX_CWND, 32'd65535);
					write_reg(REG_GAIN, 32'd4); write_reg(REG_INIT, 32'd14600);
				end
				1: begin
					write_reg(REG_MSS, 32'd65535); write_reg(REG_MAX_CWND, U32_MAX);
					write_reg(REG_GAIN, 32'd0); write_reg(REG_INIT, U32_MAX);
				end
				2: begin
					write_reg(REG_MSS, 32'd1); write_reg(REG_MAX_CWND, 32'd1);
					write_reg(REG_GAIN, 32'd10); write_reg(REG_INIT, 32'd0);
				end
				3: begin
					write_reg(REG_MSS, 32'd9000); write_reg(REG_MAX_CWND, 32'd1000000);
					write_reg(REG_GAIN, 32'd15); write_reg(REG_INIT, 32'd20000);
				end
				default: begin
					write_reg(REG_MSS, $urandom_range(1, 65535));
					write_reg(REG_MAX_CWND, $urandom());
					write_reg(REG_GAIN, $urandom_range(15));
					write_reg(REG_INIT, $urandom());
				end
			endcase
			calm = (ph == 3);
			if (ph == 4) hold_off = 1500;
			repeat (200) send_item(rand_item());
			drain();
		end

		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
